// File: design/kms_pkg.sv
// shared constants, types and helpers for the key matrix scan and debounce block
`default_nettype none
package kms_pkg;

   localparam int NUM_COLUMNS = 12;
   localparam int ROW_WIDTH   = 8;
   localparam int COL_W       = 4;
   localparam int KEY_W       = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KEY_W-1:0] MAX_KEY_RESET = 7'd92;
   localparam logic [COL_W-1:0] LAST_COLUMN   = COL_W'(NUM_COLUMNS - 1);

   typedef logic [NUM_COLUMNS-1:0][ROW_WIDTH-1:0] frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // rows of column col whose scan code col*8+row+1 does not exceed limit
   function automatic logic [ROW_WIDTH-1:0] limit_mask(input logic [COL_W-1:0] col,
                                                       input logic [KEY_W-1:0] limit);
      logic [7:0] base;
      logic [7:0] lim;
      logic [7:0] diff;
      logic [ROW_WIDTH-1:0] mask;
      base = {1'b0, col, 3'b000};
      lim  = {1'b0, limit};
      diff = lim - base;
      if (lim >= base + 8'd8) begin
         mask = '1;
      end else if (lim <= base) begin
         mask = '0;
      end else begin
         mask = (ROW_WIDTH'(1) << diff[2:0]) - ROW_WIDTH'(1);
      end
      return mask;
   endfunction

endpackage
`default_nettype wire

// File: design/kms_if.sv
// request and response channel interfaces
`default_nettype none
interface kms_req_if;
   import kms_pkg::*;
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] column_index;
   logic [7:0]       row_bits;

   modport source (output valid, output column_index, output row_bits, input ready);
   modport sink   (input valid, input column_index, input row_bits, output ready);
endinterface

interface kms_rsp_if;
   import kms_pkg::*;
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] out_column;
   logic [7:0]       new_row_bits;
   logic [7:0]       change_mask;
   logic             last_of_run;

   modport source (output valid, output out_column, output new_row_bits,
                   output change_mask, output last_of_run, input ready);
   modport sink   (input valid, input out_column, input new_row_bits,
                   input change_mask, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: design/key_matrix_scan_debounce.sv
// top level of the key matrix scan and debounce block
// The block takes one column reading per transfer (column index and 8 row bits)
// and, when the highest column arrives, checks the frame against the previous
// one; a stable frame is compared with the accepted key state and one result
// per changed column is sent in rising column order, the final one flagged with
// last_of_run. Column readings are taken one per cycle while the two-entry frame
// queue has room. The back end walks the twelve columns of a queued frame one
// column per cycle while the output slot is free or the column has no change.
// Indexes above the last column are ignored. max_key_code is written through
// csr_wr_en and csr_wr_data while the block is idle, a rule on the user that
// the block does not enforce; changes of scan codes above it are not reported.
`default_nettype none
module key_matrix_scan_debounce (
   input  wire                      clock,
   input  wire                      reset,
   kms_req_if.sink                  req_chan,
   kms_rsp_if.source                rsp_chan,
   input  wire                      csr_wr_en,
   input  wire [kms_pkg::KEY_W-1:0] csr_wr_data
);
   import kms_pkg::*;

   logic [KEY_W-1:0] max_key_ff;
   logic             push;
   logic             pop;
   frame_type        push_frame;
   frame_type        head;
   q_status_type     q_status;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_key_ff <= MAX_KEY_RESET;
      end else if (csr_wr_en) begin
         max_key_ff <= csr_wr_data;
      end
   end

   kms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_status   (q_status),
      .push       (push),
      .push_frame (push_frame)
   );

   kms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   kms_back u_back (
      .clock        (clock),
      .reset        (reset),
      .max_key_code (max_key_ff),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule
`default_nettype wire

// File: design/kms_front.sv
// front end: collects column readings into a frame and forwards stable frames
`default_nettype none
module kms_front (
   input  wire                  clock,
   input  wire                  reset,
   kms_req_if.sink              req_chan,
   input  kms_pkg::q_status_type q_status,
   output logic                 push,
   output kms_pkg::frame_type   push_frame
);
   import kms_pkg::*;

   frame_type frame_ff, frame_in;
   frame_type prev_ff, prev_in;
   logic      accept;
   logic      in_range;
   logic      frame_end;

   // transfer only when the queue can take a finished frame
   assign req_chan.ready = !q_status.full;
   assign accept    = req_chan.valid && req_chan.ready;
   assign in_range  = {1'b0, req_chan.column_index} < (COL_W + 1)'(NUM_COLUMNS);
   assign frame_end = in_range && (req_chan.column_index == LAST_COLUMN);

   // frame with the incoming column written in
   always_comb begin
      frame_in = frame_ff;
      prev_in  = prev_ff;
      if (accept && in_range) begin
         frame_in[req_chan.column_index] = req_chan.row_bits;
      end
      if (accept && frame_end) begin
         prev_in = frame_in;
      end
   end

   // stable frame goes to the back end
   assign push       = accept && frame_end && (frame_in == prev_ff);
   assign push_frame = frame_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         prev_ff  <= '0;
      end else begin
         frame_ff <= frame_in;
         prev_ff  <= prev_in;
      end
   end

endmodule
`default_nettype wire

// File: design/kms_queue.sv
// short queue of stable frames between front and back end
`default_nettype none
module kms_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  kms_pkg::frame_type    push_frame,
   input  wire                   pop,
   output kms_pkg::frame_type    head,
   output kms_pkg::q_status_type q_status
);
   import kms_pkg::*;

   frame_type [QUEUE_DEPTH-1:0] store_ff;
   logic [QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]           count_ff, count_in;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head           = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // frame storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_frame;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full) else $error("frame pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty) else $error("frame popped from empty queue");

endmodule
`default_nettype wire

// File: design/kms_back.sv
// back end: compares a stable frame with the accepted state and emits column changes
`default_nettype none
module kms_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [kms_pkg::KEY_W-1:0] max_key_code,
   input  kms_pkg::frame_type    head,
   input  kms_pkg::q_status_type q_status,
   output logic                  pop,
   kms_rsp_if.source             rsp_chan
);
   import kms_pkg::*;

   typedef enum logic {IDLE, SCAN} state_type;

   state_type            state_ff;
   frame_type            accepted_ff;
   frame_type            job_ff;
   frame_type            chg_ff;
   frame_type            chg_in;
   logic [COL_W-1:0]     col_ff;
   logic                 rsp_valid_ff;
   logic [COL_W-1:0]     out_column_ff;
   logic [7:0]           new_row_bits_ff;
   logic [7:0]           change_mask_ff;
   logic                 last_of_run_ff;
   logic [NUM_COLUMNS-1:0] chg_flag;
   logic                 later_change;
   logic                 slot_free;
   logic                 emit;
   logic                 advance;

   // change masks of a new job against the accepted state
   always_comb begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
         chg_in[i] = (head[i] ^ accepted_ff[i]) & limit_mask(COL_W'(i), max_key_code);
      end
   end

   // any change left in a column above the current one
   always_comb begin
      later_change = 1'b0;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
         chg_flag[i] = |chg_ff[i];
         if (chg_flag[i] && (COL_W'(i) > col_ff)) begin
            later_change = 1'b1;
         end
      end
   end

   assign pop       = (state_ff == IDLE) && !q_status.empty;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = (state_ff == SCAN) && chg_flag[col_ff] && slot_free;
   assign advance   = (state_ff == SCAN) && (!chg_flag[col_ff] || slot_free);

   // sequencer over the columns of one frame
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= '0;
      end else begin
         // output slot empties on a transfer unless a new result refills it
         if (rsp_valid_ff && rsp_chan.ready && !emit) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (pop) begin
                  job_ff      <= head;
                  chg_ff      <= chg_in;
                  accepted_ff <= head;
                  col_ff      <= '0;
                  state_ff    <= SCAN;
               end
            end
            SCAN: begin
               if (emit) begin
                  rsp_valid_ff    <= 1'b1;
                  out_column_ff   <= col_ff;
                  new_row_bits_ff <= job_ff[col_ff];
                  change_mask_ff  <= chg_ff[col_ff];
                  last_of_run_ff  <= !later_change;
               end
               if (advance) begin
                  if (col_ff == LAST_COLUMN) begin
                     state_ff <= IDLE;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_column   = out_column_ff;
   assign rsp_chan.new_row_bits = new_row_bits_ff;
   assign rsp_chan.change_mask  = change_mask_ff;
   assign rsp_chan.last_of_run  = last_of_run_ff;

   a_mask_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (change_mask_ff != '0)) else $error("result with empty change mask");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN) |-> ({1'b0, col_ff} < (COL_W + 1)'(NUM_COLUMNS)))
      else $error("scan column out of range");

endmodule
`default_nettype wire

// File: verif/key_matrix_scan_debounce_tb.sv
// testbench for the key matrix scan and debounce block: column readings in, checked key changes out
`default_nettype none
module key_matrix_scan_debounce_tb;
   import kms_pkg::*;

   localparam int TIMEOUT_CYCLES = 400000;
   localparam int DRAIN_LIMIT    = 8000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int RANDOM_READINGS = 130;
   localparam int HOLD_CYCLES    = 300;

   typedef struct {
      logic [COL_W-1:0]     column;
      logic [ROW_WIDTH-1:0] rows;
      logic [ROW_WIDTH-1:0] changed;
      logic                 ends_run;
   } key_change_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             csr_wr_en;
   logic [KEY_W-1:0] csr_wr_data;

   kms_req_if req_chan ();
   kms_rsp_if rsp_chan ();

   key_matrix_scan_debounce dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: scanned frame, frame before it, debounced key state, limit
   frame_type        scan_frame;
   frame_type        prior_frame;
   frame_type        debounced;
   logic [KEY_W-1:0] key_limit;
   key_change_type   expected_changes[$];

   int unsigned readings_sent = 0;
   int unsigned mismatches = 0;
   int unsigned rsp_hold_cycles = 0;
   bit          steady_flow = 1'b0;

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // rows of a column whose scan codes are within the limit
   function automatic logic [ROW_WIDTH-1:0] reportable_rows(input int col, input int lim);
      logic [ROW_WIDTH-1:0] m;
      m = '0;
      for (int r = 0; r < ROW_WIDTH; r++) m[r] = (col * ROW_WIDTH + r + 1 <= lim);
      return m;
   endfunction

   // update the predicted state with one accepted reading, queue the key changes it causes
   function automatic void predict_reading(input logic [COL_W-1:0] col,
                                           input logic [ROW_WIDTH-1:0] rows);
      logic [ROW_WIDTH-1:0] changed [NUM_COLUMNS];
      int                   last_changed;
      key_change_type       item;
      if (col >= NUM_COLUMNS) return;
      scan_frame[col] = rows;
      if (col != LAST_COLUMN) return;
      // a frame that differs from the one before is still bouncing
      if (scan_frame != prior_frame) begin
         prior_frame = scan_frame;
         return;
      end
      last_changed = -1;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         changed[c] = (scan_frame[c] ^ debounced[c]) & reportable_rows(c, key_limit);
         if (changed[c] != '0) last_changed = c;
      end
      for (int c = 0; c <= last_changed; c++) begin
         if (changed[c] != '0) begin
            item.column   = COL_W'(c);
            item.rows     = scan_frame[c];
            item.changed  = changed[c];
            item.ends_run = (c == last_changed);
            expected_changes.push_back(item);
         end
      end
      debounced = scan_frame;
   endfunction

   function automatic logic [ROW_WIDTH-1:0] random_rows();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return ROW_WIDTH'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // one column reading, after a random gap unless steady_flow is set
   task automatic send_reading(input logic [COL_W-1:0] col, input logic [ROW_WIDTH-1:0] rows);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 19);
      repeat (gap) @(negedge clock) req_chan.valid <= 1'b0;
      @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.column_index <= col;
      req_chan.row_bits     <= rows;
      do @(posedge clock); while (!req_chan.ready);
      predict_reading(col, rows);
      if (col < NUM_COLUMNS) readings_sent++;
   endtask

   // scan a frame: columns that differ (or all), optional noise on out-of-range columns, then the closing column
   task automatic send_scan(input frame_type f, input bit whole, input bit noisy);
      for (int c = 0; c < NUM_COLUMNS - 1; c++) begin
         if (noisy && $urandom_range(0, 7) == 0) begin
            send_reading(COL_W'($urandom_range(NUM_COLUMNS, 15)), random_rows());
         end
         if (whole || f[c] != scan_frame[c]) send_reading(COL_W'(c), f[c]);
      end
      send_reading(LAST_COLUMN, f[NUM_COLUMNS-1]);
   endtask

   task automatic write_key_limit(input logic [KEY_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock) csr_wr_en <= 1'b0;
      key_limit = value;
   endtask

   // let every expected key change arrive, then let queued frames settle
   task automatic wait_until_quiet();
      int unsigned waited;
      @(negedge clock) req_chan.valid <= 1'b0;
      waited = 0;
      while (expected_changes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (expected_changes.size() != 0) begin
         $error("%0d expected key changes never arrived", expected_changes.size());
         mismatches++;
         expected_changes.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // compare one response transfer with the oldest expected key change
   task automatic check_key_change();
      key_change_type want;
      if (expected_changes.size() == 0) begin
         $error("key change on column %0d with none expected", rsp_chan.out_column);
         mismatches++;
         return;
      end
      want = expected_changes.pop_front();
      if (rsp_chan.out_column !== want.column) begin
         $error("out_column: expected %0d, actual %0d", want.column, rsp_chan.out_column);
         mismatches++;
      end
      if (rsp_chan.new_row_bits !== want.rows) begin
         $error("new_row_bits: expected 0x%02h, actual 0x%02h", want.rows,
                rsp_chan.new_row_bits);
         mismatches++;
      end
      if (rsp_chan.change_mask !== want.changed) begin
         $error("change_mask: expected 0x%02h, actual 0x%02h", want.changed,
                rsp_chan.change_mask);
         mismatches++;
      end
      if (rsp_chan.last_of_run !== want.ends_run) begin
         $error("last_of_run: expected %0b, actual %0b", want.ends_run, rsp_chan.last_of_run);
         mismatches++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_key_change();
   end

   // response ready: random stalls, or a long hold when one is requested
   initial begin : rsp_ready_driver
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = steady_flow ? 0 : $urandom_range(0, 19);
         end
         repeat (stall) @(negedge clock) rsp_chan.ready <= 1'b0;
         @(negedge clock) rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid && rsp_hold_cycles == 0);
      end
   end

   // out-of-range columns are dropped and end no frame
   task automatic test_ignored_columns();
      send_reading(COL_W'(12), 8'hff);
      send_reading(COL_W'(15), 8'hff);
      send_reading(COL_W'(13), 8'h5a);
      send_reading(COL_W'(14), 8'ha5);
      send_reading(LAST_COLUMN, 8'h00);
      wait_until_quiet();
   endtask

   // all-ones and alternating rows, columns not driven keep their old reading
   task automatic test_full_frame_extremes();
      send_reading(COL_W'(0), 8'hff);
      send_reading(COL_W'(5), 8'haa);
      send_reading(COL_W'(10), 8'h55);
      send_reading(LAST_COLUMN, 8'hff);
      send_reading(LAST_COLUMN, 8'hff);
      wait_until_quiet();
   endtask

   // bouncing frames report nothing until two in a row agree
   task automatic test_unstable_frames();
      send_reading(COL_W'(3), 8'h81);
      send_reading(LAST_COLUMN, 8'hff);
      send_reading(COL_W'(3), 8'h7e);
      send_reading(LAST_COLUMN, 8'hff);
      send_reading(LAST_COLUMN, 8'hff);
      wait_until_quiet();
   endtask

   // changes only on codes above the limit: no report, state still taken
   task automatic test_changes_above_limit();
      send_reading(LAST_COLUMN, 8'h0f);
      send_reading(LAST_COLUMN, 8'h0f);
      send_reading(LAST_COLUMN, 8'h1f);
      send_reading(LAST_COLUMN, 8'h1f);
      wait_until_quiet();
   endtask

   // limit settings from zero to full range, edges of first and last column toggled
   task automatic test_limit_settings();
      int        limit_steps[7] = '{0, 1, 96, 127, 8, 93, 92};
      frame_type target;
      foreach (limit_steps[i]) begin
         wait_until_quiet();
         write_key_limit(KEY_W'(limit_steps[i]));
         target = scan_frame;
         target[0] = ~target[0];
         target[NUM_COLUMNS-1] = ~target[NUM_COLUMNS-1];
         target[$urandom_range(1, NUM_COLUMNS - 2)] ^= random_rows();
         send_scan(target, 1'b0, 1'b0);
         send_reading(LAST_COLUMN, target[NUM_COLUMNS-1]);
      end
      wait_until_quiet();
   endtask

   // long response hold while whole toggled frames keep coming
   task automatic test_backpressure();
      frame_type target;
      write_key_limit(KEY_W'(96));
      steady_flow = 1'b1;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (4) begin
         target = ~scan_frame;
         send_scan(target, 1'b1, 1'b0);
         send_reading(LAST_COLUMN, target[NUM_COLUMNS-1]);
      end
      wait_until_quiet();
      steady_flow = 1'b0;
   endtask

   // random scans: mostly settled frames, some noise and bouncing frames
   task automatic test_random_scans();
      int unsigned goal;
      int unsigned next_setting;
      int unsigned kind;
      frame_type   target;
      goal = readings_sent + RANDOM_READINGS;
      next_setting = readings_sent;
      while (readings_sent < goal) begin
         if (readings_sent >= next_setting) begin
            wait_until_quiet();
            write_key_limit($urandom_range(0, 3) == 0 ? MAX_KEY_RESET
                                                       : KEY_W'($urandom_range(0, 127)));
            steady_flow = ($urandom_range(0, 3) == 0);
            next_setting = readings_sent + 60;
         end
         target = scan_frame;
         repeat ($urandom_range(1, 4)) target[$urandom_range(0, NUM_COLUMNS - 1)] = random_rows();
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            send_scan(target, $urandom_range(0, 3) == 0, 1'b1);
            send_scan(target, $urandom_range(0, 5) == 0, 1'b1);
         end else if (kind == 7) begin
            repeat ($urandom_range(1, 4)) begin
               send_reading(COL_W'($urandom_range(NUM_COLUMNS, 15)), random_rows());
            end
         end else begin
            send_scan(target, $urandom_range(0, 1) == 0, 1'b1);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin : test_sequence
      req_chan.valid        = 1'b0;
      req_chan.column_index = '0;
      req_chan.row_bits     = '0;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      scan_frame  = '0;
      prior_frame = '0;
      debounced   = '0;
      key_limit   = MAX_KEY_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_ignored_columns();
      test_full_frame_extremes();
      test_unstable_frames();
      test_changes_above_limit();
      test_limit_settings();
      test_backpressure();
      test_random_scans();
      wait_until_quiet();

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // run limit
   initial begin : run_limit
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
design/kms_pkg.sv
design/kms_if.sv
design/kms_front.sv
design/kms_queue.sv
design/kms_back.sv
design/key_matrix_scan_debounce.sv
verif/key_matrix_scan_debounce_tb.sv
